@@ rtl/core/edn_pkg.sv @@
// Shared types and constants for the Euclidean distance and RMS norm unit.
package edn_pkg;

	localparam int COUNT_W     = 25;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int TOTAL_W     = 17;
	localparam int ROOT_W      = 32;

	typedef struct packed {
		logic [63:0]        sum;
		logic [COUNT_W-1:0] count;
		logic               ovf;
		logic               mode;
	} job_t;

endpackage

@@ rtl/core/edn_front.sv @@
// Front end: takes element pairs, squares the difference and accumulates per vector.
module edn_front #(
	parameter int MAX_LENGTH   = 65536,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [31:0]        first_value,
	input  logic [31:0]        second_value,
	input  logic               first_present,
	input  logic               second_present,
	input  logic               mode,
	input  logic               last,
	output logic               push,
	output edn_pkg::job_t      push_job,
	input  logic               queue_full
);
	import edn_pkg::*;

	localparam int CNT_W = $clog2(MAX_LENGTH + 1);

	logic               v_s1, last_s1, mode_s1;
	logic [31:0]        mag_s1;
	logic               v_s2, last_s2, mode_s2;
	logic [63:0]        sq_s2;
	logic [63:0]        sum_q;
	logic [CNT_W-1:0]   count_q;
	logic               ovf_q;

	logic               advance;
	logic signed [31:0] a_ext, b_ext;
	logic signed [32:0] diff;
	logic [32:0]        diff_mag;
	logic [64:0]        sum_add;
	logic               cnt_full;
	logic [63:0]        new_sum;
	logic [CNT_W-1:0]   new_count;
	logic               new_ovf;

	assign advance  = !(v_s2 && last_s2 && queue_full);
	assign in_ready = advance;

	assign a_ext    = first_present  ? 32'(signed'(first_value[SAMPLE_WIDTH-1:0]))  : '0;
	assign b_ext    = second_present ? 32'(signed'(second_value[SAMPLE_WIDTH-1:0])) : '0;
	assign diff     = 33'(a_ext) - 33'(b_ext);
	assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);

	assign sum_add   = {1'b0, sum_q} + {1'b0, sq_s2};
	assign cnt_full  = count_q >= CNT_W'(MAX_LENGTH);
	assign new_sum   = cnt_full ? sum_q : (sum_add[64] ? '1 : sum_add[63:0]);
	assign new_count = cnt_full ? count_q : count_q + CNT_W'(1);
	assign new_ovf   = ovf_q | cnt_full | sum_add[64];

	assign push           = advance && v_s2 && last_s2;
	assign push_job.sum   = new_sum;
	assign push_job.count = COUNT_W'(new_count);
	assign push_job.ovf   = new_ovf;
	assign push_job.mode  = mode_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			sum_q   <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (advance) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			if (v_s2) begin
				if (last_s2) begin
					sum_q   <= '0;
					count_q <= '0;
					ovf_q   <= 1'b0;
				end else begin
					sum_q   <= new_sum;
					count_q <= new_count;
					ovf_q   <= new_ovf;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mag_s1  <= diff_mag[31:0];
			last_s1 <= last;
			mode_s1 <= mode;
			sq_s2   <= 64'(mag_s1) * 64'(mag_s1);
			last_s2 <= last_s1;
			mode_s2 <= mode_s1;
		end
	end

endmodule

@@ rtl/core/edn_queue.sv @@
// Short job queue between the accumulating front end and the root back end.
module edn_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  edn_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output edn_pkg::job_t head_job,
	output logic          empty
);
	import edn_pkg::*;

	job_t              slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   fill_q;

	assign full     = fill_q == (QPTR_W + 1)'(QUEUE_DEPTH);
	assign empty    = fill_q == '0;
	assign head_job = slots_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + QPTR_W'(1);
			if (pop)  rd_q <= rd_q + QPTR_W'(1);
			if (push && !pop)      fill_q <= fill_q + (QPTR_W + 1)'(1);
			else if (pop && !push) fill_q <= fill_q - (QPTR_W + 1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) slots_q[wr_q] <= push_job;
	end

endmodule

@@ rtl/core/edn_back.sv @@
// Back end: optional mean division, bit-serial square root, rounding and result register.
module edn_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          job_avail,
	input  edn_pkg::job_t                 job,
	output logic                          job_pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [edn_pkg::ROOT_W-1:0]    distance,
	output logic [edn_pkg::TOTAL_W-1:0]   element_total,
	output logic                          saturated
);
	import edn_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_ROOT,
		ST_ROUND,
		ST_DONE
	} state_t;

	state_t             state_q;
	logic [63:0]        x_q;
	logic [COUNT_W-1:0] div_q;
	logic [COUNT_W-1:0] drem_q;
	logic [32:0]        srem_q;
	logic [31:0]        root_q;
	logic [5:0]         step_q;
	logic [31:0]        dist_q;
	logic [TOTAL_W-1:0] total_q;
	logic               sat_q;

	logic [COUNT_W:0]   dsh, ddiff;
	logic               dge;
	logic [34:0]        ssh, strial, sdiff;
	logic               sge;
	logic               round_up;

	assign dsh   = {drem_q, x_q[63]};
	assign dge   = dsh >= {1'b0, div_q};
	assign ddiff = dsh - {1'b0, div_q};

	assign ssh    = {srem_q, x_q[63:62]};
	assign strial = {1'b0, root_q, 2'b01};
	assign sge    = ssh >= strial;
	assign sdiff  = ssh - strial;

	assign round_up = (srem_q > {1'b0, root_q}) && (root_q != '1);

	assign job_pop       = (state_q == ST_IDLE) && job_avail;
	assign out_valid     = state_q == ST_DONE;
	assign distance      = dist_q;
	assign element_total = total_q;
	assign saturated     = sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			x_q     <= '0;
			div_q   <= '0;
			drem_q  <= '0;
			srem_q  <= '0;
			root_q  <= '0;
			dist_q  <= '0;
			total_q <= '0;
			sat_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					x_q     <= job.sum;
					div_q   <= job.count;
					drem_q  <= '0;
					srem_q  <= '0;
					root_q  <= '0;
					total_q <= job.count[TOTAL_W-1:0];
					sat_q   <= job.ovf;
					if (job_avail) begin
						if (job.mode && job.count != '0) begin
							state_q <= ST_DIV;
							step_q  <= 6'd63;
						end else begin
							state_q <= ST_ROOT;
							step_q  <= 6'd31;
						end
					end
				end
				ST_DIV: begin
					drem_q <= dge ? ddiff[COUNT_W-1:0] : dsh[COUNT_W-1:0];
					x_q    <= {x_q[62:0], dge};
					if (step_q == '0) begin
						state_q <= ST_ROOT;
						step_q  <= 6'd31;
					end else begin
						step_q <= step_q - 6'd1;
					end
				end
				ST_ROOT: begin
					srem_q <= sge ? sdiff[32:0] : ssh[32:0];
					root_q <= {root_q[30:0], sge};
					x_q    <= {x_q[61:0], 2'b00};
					if (step_q == '0) state_q <= ST_ROUND;
					else              step_q  <= step_q - 6'd1;
				end
				ST_ROUND: begin
					dist_q  <= root_q + 32'(round_up);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/core/euclidean_distance_norm_unit.sv @@
// Top level of the Euclidean distance and RMS norm unit.
// Throughput: one element pair per cycle while the four-entry job queue has room; the back
// end handles one vector at a time, and a full queue stalls the input. For the mean, the back
// end runs a 64-step serial divide, then a 32-step serial root; the plain root skips the divide.
// Reset: arst_n asynchronously clears sums, counts, queue and sequencer.
module euclidean_distance_norm_unit #(
	parameter int MAX_LENGTH   = 65536,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// first_value[31:0], second_value[63:32], first_present[64], second_present[65]
	input  logic [71:0] s_axis_tdata,
	// mode[0]
	input  logic        s_axis_tuser,
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// distance[31:0], element_total[48:32], saturated[49]
	output logic [55:0] m_axis_tdata
);
	import edn_pkg::*;

	logic                push, queue_full, pop, queue_empty;
	job_t                push_job, head_job;
	logic [ROOT_W-1:0]   distance;
	logic [TOTAL_W-1:0]  element_total;
	logic                saturated;

	edn_front #(
		.MAX_LENGTH  (MAX_LENGTH),
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.first_value   (s_axis_tdata[31:0]),
		.second_value  (s_axis_tdata[63:32]),
		.first_present (s_axis_tdata[64]),
		.second_present(s_axis_tdata[65]),
		.mode          (s_axis_tuser),
		.last          (s_axis_tlast),
		.push          (push),
		.push_job      (push_job),
		.queue_full    (queue_full)
	);

	edn_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.full    (queue_full),
		.pop     (pop),
		.head_job(head_job),
		.empty   (queue_empty)
	);

	edn_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_avail    (!queue_empty),
		.job          (head_job),
		.job_pop      (pop),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.distance     (distance),
		.element_total(element_total),
		.saturated    (saturated)
	);

	assign m_axis_tdata = {6'b0, saturated, element_total, distance};

endmodule
